// ===== src/gds_pkg.sv =====
// Shared codes, constants and the month length helper for the Gregorian date stepper.
`timescale 1ns / 1ps

package gds_pkg;

   // Request command codes.
   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_ADD_D = 3'd1;
   localparam logic [2:0] CMD_SUB_D = 3'd2;
   localparam logic [2:0] CMD_ADD_M = 3'd3;
   localparam logic [2:0] CMD_SUB_M = 3'd4;
   localparam logic [2:0] CMD_ADD_Y = 3'd5;
   localparam logic [2:0] CMD_SUB_Y = 3'd6;

   // Response status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   localparam int YEAR_MAX_DEFAULT = 9999;

   localparam logic [13:0] RESET_YEAR  = 14'd2000;
   localparam logic [3:0]  RESET_MONTH = 4'd1;
   localparam logic [4:0]  RESET_DAY   = 5'd1;

   // Reciprocals for division by constants: floor(x * R >> S) is exact over the operand range.
   localparam logic [15:0] RECIP25 = 16'd41944;  // shift 20, years below 16384
   localparam logic [15:0] RECIP12 = 16'd43691;  // shift 19, amounts below 65536

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Length of a month; a month code outside 1 to 12 counts as 31 days.
   function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
      logic [4:0] len;
      len = 5'd31;
      if (month >= 4'd1 && month <= 4'd12) begin
         len = MONTH_LEN[month - 4'd1];
      end
      if (month == 4'd2 && leap) begin
         len = 5'd29;
      end
      return len;
   endfunction

endpackage

// ===== src/gds_mul.sv =====
// Shared 16 by 16 multiplier with a registered product.
`timescale 1ns / 1ps

module gds_mul (
   input  logic        clock,
   input  logic [15:0] mul_a,
   input  logic [15:0] mul_b,
   output logic [31:0] mul_prod
);

   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign prod_in  = mul_a * mul_b;
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== src/gregorian_date_stepper.sv =====
// Top level of the Gregorian date stepper: sequencer, working date and response register.
`timescale 1ns / 1ps

// The block holds one Gregorian date and answers every request with the date that holds
// afterwards and a status code. A request is taken when req_valid is high and req_stall is
// low; the response is taken when rsp_valid is high and rsp_stall is low.
// Each request is worked through by a small sequencer around one shared multiplier, which
// serves both the leap year test (a divide by 25) and the month split (a divide by 12).
// req_stall is high from the cycle after a request is taken until its response has been
// loaded into the output register, so the block works on one request at a time.
// A load runs the leap test and then the date check; a year move checks the year range,
// then runs the leap test and clamps the day to the month; a month move first splits the
// amount by 12 and applies it, then goes on as a year move. A move refused by the year
// range check answers without the later steps. Day moves advance one whole month
// per cycle, with a pass through the leap test whenever a year boundary is crossed.
// The next request can be taken at the edge after rsp_valid rises.
// A new request may be taken while a finished response still waits in the output register;
// if the receiver stalls, the next response waits in the sequencer and the date it would
// commit is held back until the output register is free.
// Reset is synchronous and puts the date at 1 January 2000 with no response pending. A
// refused request keeps the stored date and returns it with a non-zero status.

module gregorian_date_stepper
   import gds_pkg::*;
#(
   parameter int YEAR_MAX = YEAR_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_amount,
   input  logic [13:0] req_load_year,
   input  logic [3:0]  req_load_month,
   input  logic [4:0]  req_load_day,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_cur_year,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic [1:0]  rsp_status
);

   localparam logic signed [17:0] YMAX_S = 18'(YEAR_MAX);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEAP_MUL,
      ST_LEAP_EVAL,
      ST_LOAD_CHK,
      ST_DAY_STEP,
      ST_MDIV_MUL,
      ST_MDIV_EVAL,
      ST_MAPPLY,
      ST_RCHK,
      ST_CLAMP,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [15:0]        amt_ff, amt_in;
   logic [15:0]        rem_ff, rem_in;
   logic [3:0]         mrem_ff, mrem_in;
   logic signed [17:0] wy_ff, wy_in;
   logic [3:0]         wm_ff, wm_in;
   logic [4:0]         wd_ff, wd_in;
   logic               leap_ff, leap_in;
   logic [1:0]         status_ff, status_in;
   logic [13:0]        year_ff, year_in;
   logic [3:0]         month_ff, month_in;
   logic [4:0]         day_ff, day_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [13:0]        rsp_year_ff, rsp_year_in;
   logic [3:0]         rsp_month_ff, rsp_month_in;
   logic [4:0]         rsp_day_ff, rsp_day_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [15:0]        mul_a, mul_b;
   logic [31:0]        mul_prod;

   logic [13:0]        y14;
   logic [9:0]         q25;
   logic [13:0]        q25x;
   logic               div25;
   logic               leap_now;
   logic [12:0]        q12;
   logic [15:0]        q12x;
   logic [15:0]        r12;
   logic [4:0]         dim;
   logic [4:0]         left;
   logic [4:0]         msum;
   logic signed [17:0] q_s;
   logic signed [17:0] wy_up, wy_dn;
   logic               req_take;

   // The multiplier is fed the working year for the leap test, or the month count for the
   // split into years and months.
   assign mul_a = (state_ff == ST_MDIV_MUL) ? amt_ff : {2'd0, y14};
   assign mul_b = (state_ff == ST_MDIV_MUL) ? RECIP12 : RECIP25;

   gds_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   // Leap test: divisible by 4, and either not by 25 or also by 16.
   assign y14      = wy_ff[13:0];
   assign q25      = mul_prod[29:20];
   assign q25x     = ({4'd0, q25} << 4) + ({4'd0, q25} << 3) + {4'd0, q25};
   assign div25    = (y14 == q25x);
   assign leap_now = (y14[1:0] == 2'd0) && (!div25 || (y14[3:0] == 4'd0));

   // Month count split: quotient in whole years, remainder in months.
   assign q12  = mul_prod[31:19];
   assign q12x = ({3'd0, q12} << 3) + ({3'd0, q12} << 2);
   assign r12  = amt_ff - q12x;

   assign dim   = days_in(wm_ff, leap_ff);
   assign left  = dim - wd_ff;
   assign msum  = {1'b0, wm_ff} + {1'b0, mrem_ff};
   assign q_s   = $signed({5'd0, rem_ff[12:0]});
   assign wy_up = wy_ff + 18'sd1;
   assign wy_dn = wy_ff - 18'sd1;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      amt_in        = amt_ff;
      rem_in        = rem_ff;
      mrem_in       = mrem_ff;
      wy_in         = wy_ff;
      wm_in         = wm_ff;
      wd_in         = wd_ff;
      leap_in       = leap_ff;
      status_in     = status_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in    = req_cmd;
               amt_in    = req_amount;
               rem_in    = req_amount;
               wy_in     = $signed({4'd0, year_ff});
               wm_in     = month_ff;
               wd_in     = day_ff;
               status_in = STATUS_OK;
               unique case (req_cmd) inside
                  CMD_LOAD: begin
                     wy_in    = $signed({4'd0, req_load_year});
                     wm_in    = req_load_month;
                     wd_in    = req_load_day;
                     state_in = ST_LEAP_MUL;
                  end
                  CMD_ADD_D, CMD_SUB_D: begin
                     state_in = ST_LEAP_MUL;
                  end
                  CMD_ADD_M, CMD_SUB_M: begin
                     state_in = ST_MDIV_MUL;
                  end
                  CMD_ADD_Y: begin
                     wy_in    = $signed({4'd0, year_ff}) + $signed({2'd0, req_amount});
                     state_in = ST_RCHK;
                  end
                  CMD_SUB_Y: begin
                     wy_in    = $signed({4'd0, year_ff}) - $signed({2'd0, req_amount});
                     state_in = ST_RCHK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_LEAP_MUL: begin
            state_in = ST_LEAP_EVAL;
         end

         ST_LEAP_EVAL: begin
            leap_in = leap_now;
            unique case (cmd_ff) inside
               CMD_LOAD:             state_in = ST_LOAD_CHK;
               CMD_ADD_D, CMD_SUB_D: state_in = ST_DAY_STEP;
               default:              state_in = ST_CLAMP;
            endcase
         end

         ST_LOAD_CHK: begin
            if (wy_ff >= 18'sd1 && wy_ff <= YMAX_S && wm_ff >= 4'd1 && wm_ff <= 4'd12
                && wd_ff >= 5'd1 && wd_ff <= dim) begin
               status_in = STATUS_OK;
            end else begin
               status_in = STATUS_INVALID;
            end
            state_in = ST_DONE;
         end

         // One month per cycle: a remaining count that reaches past the month moves to the
         // first (or last) day of the neighbouring month, otherwise the day is set directly.
         ST_DAY_STEP: begin
            if (rem_ff == 16'd0) begin
               state_in = ST_DONE;
            end else if (cmd_ff == CMD_ADD_D) begin
               if (rem_ff > {11'd0, left}) begin
                  rem_in = rem_ff - {11'd0, left} - 16'd1;
                  wd_in  = 5'd1;
                  if (wm_ff == 4'd12) begin
                     wm_in = 4'd1;
                     wy_in = wy_up;
                     if (wy_up > YMAX_S) begin
                        status_in = STATUS_RANGE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_LEAP_MUL;
                     end
                  end else begin
                     wm_in = wm_ff + 4'd1;
                  end
               end else begin
                  wd_in    = wd_ff + rem_ff[4:0];
                  rem_in   = 16'd0;
                  state_in = ST_DONE;
               end
            end else begin
               if (rem_ff >= {11'd0, wd_ff}) begin
                  rem_in = rem_ff - {11'd0, wd_ff};
                  if (wm_ff == 4'd1) begin
                     wm_in = 4'd12;
                     wd_in = 5'd31;
                     wy_in = wy_dn;
                     if (wy_dn < 18'sd1) begin
                        status_in = STATUS_RANGE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_LEAP_MUL;
                     end
                  end else begin
                     wm_in = wm_ff - 4'd1;
                     wd_in = days_in(wm_ff - 4'd1, leap_ff);
                  end
               end else begin
                  wd_in    = wd_ff - rem_ff[4:0];
                  rem_in   = 16'd0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_MDIV_MUL: begin
            state_in = ST_MDIV_EVAL;
         end

         ST_MDIV_EVAL: begin
            rem_in   = {3'd0, q12};
            mrem_in  = r12[3:0];
            state_in = ST_MAPPLY;
         end

         ST_MAPPLY: begin
            if (cmd_ff == CMD_ADD_M) begin
               if (msum > 5'd12) begin
                  wm_in = 4'(msum - 5'd12);
                  wy_in = wy_ff + q_s + 18'sd1;
               end else begin
                  wm_in = msum[3:0];
                  wy_in = wy_ff + q_s;
               end
            end else begin
               if (wm_ff > mrem_ff) begin
                  wm_in = wm_ff - mrem_ff;
                  wy_in = wy_ff - q_s;
               end else begin
                  wm_in = 4'({1'b0, wm_ff} + 5'd12 - {1'b0, mrem_ff});
                  wy_in = wy_ff - q_s - 18'sd1;
               end
            end
            state_in = ST_RCHK;
         end

         ST_RCHK: begin
            if (wy_ff < 18'sd1 || wy_ff > YMAX_S) begin
               status_in = STATUS_RANGE;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_LEAP_MUL;
            end
         end

         ST_CLAMP: begin
            if (wd_ff > dim) begin
               wd_in = dim;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == STATUS_OK) begin
                  year_in      = y14;
                  month_in     = wm_ff;
                  day_in       = wd_ff;
                  rsp_year_in  = y14;
                  rsp_month_in = wm_ff;
                  rsp_day_in   = wd_ff;
               end else begin
                  rsp_year_in  = year_ff;
                  rsp_month_in = month_ff;
                  rsp_day_in   = day_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      amt_ff        <= amt_in;
      rem_ff        <= rem_in;
      mrem_ff       <= mrem_in;
      wy_ff         <= wy_in;
      wm_ff         <= wm_in;
      wd_ff         <= wd_in;
      leap_ff       <= leap_in;
      status_ff     <= status_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         year_ff      <= RESET_YEAR;
         month_ff     <= RESET_MONTH;
         day_ff       <= RESET_DAY;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_year  = rsp_year_ff;
   assign rsp_cur_month = rsp_month_ff;
   assign rsp_cur_day   = rsp_day_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== src/gds_checker.sv =====
// Port level checks for the Gregorian date stepper and the bind that attaches them.
`timescale 1ns / 1ps

module gds_checker
   import gds_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_cur_year,
   input logic [3:0]  rsp_cur_month,
   input logic [4:0]  rsp_cur_day,
   input logic [1:0]  rsp_status
);

   // A taken request keeps the block busy for at least the next cycle.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but block not busy next cycle");

   // Every response carries a real date and a defined status.
   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cur_year != 14'd0 && rsp_cur_month >= 4'd1 && rsp_cur_month <= 4'd12
                     && rsp_cur_day >= 5'd1 && rsp_status <= STATUS_RANGE))
      else $error("response holds an impossible date or status");

   // A stalled response holds its year, day and status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cur_year)
                                    && $stable(rsp_cur_day) && $stable(rsp_status)))
      else $error("stalled response changed");

   // No response is pending straight after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response pending straight after reset");

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (.*);
